FILE: src/ctc3_pkg.sv
// shared types, constants and symbol mapping for the trigram counter
package ctc3_pkg;

  // counter width and derived widths
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SYM_BITS   = 5;
  localparam int unsigned SYM_COUNT  = 29;
  localparam int unsigned ADDR_BITS  = 3 * SYM_BITS;
  localparam int unsigned DEPTH      = 1 << ADDR_BITS;
  localparam int unsigned TOTAL_BITS = COUNT_BITS + SYM_BITS;
  localparam int unsigned OCNT_BITS  = 16;
  localparam int unsigned OTOT_BITS  = 21;

  localparam logic [SYM_BITS-1:0]   SYM_NONE  = SYM_BITS'(31);
  localparam logic [SYM_BITS-1:0]   SYM_LAST  = SYM_BITS'(SYM_COUNT - 1);
  localparam logic [ADDR_BITS-1:0]  ADDR_LAST = ADDR_BITS'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // beat modes
  localparam logic MODE_FEED  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
    logic [7:0] first_letter;
    logic [7:0] second_letter;
  } ctc3_in_t;

  typedef struct packed {
    logic [7:0]           best_char;
    logic [OCNT_BITS-1:0] best_count;
    logic [7:0]           second_char;
    logic [OCNT_BITS-1:0] second_count;
    logic [7:0]           third_char;
    logic [OCNT_BITS-1:0] third_count;
    logic [OTOT_BITS-1:0] total_count;
    logic                 no_data;
  } ctc3_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FEED,
    ST_WALK,
    ST_DONE
  } ctc3_state_e;

  // byte to symbol code, SYM_NONE when the byte is dropped
  function automatic logic [SYM_BITS-1:0] sym_of(input logic [7:0] b, input logic fold);
    logic [7:0] c;
    c = b;
    if (fold && c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'h20;
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      sym_of = SYM_BITS'(c - 8'h61 + 8'd3);
    end else if (c == 8'h20) begin
      sym_of = SYM_BITS'(0);
    end else if (c == 8'h27) begin
      sym_of = SYM_BITS'(1);
    end else if (c == 8'h2C) begin
      sym_of = SYM_BITS'(2);
    end else begin
      sym_of = SYM_NONE;
    end
  endfunction

  // symbol code back to its lower-case byte
  function automatic logic [7:0] sym_byte(input logic [SYM_BITS-1:0] s);
    if (s == SYM_BITS'(0)) begin
      sym_byte = 8'h20;
    end else if (s == SYM_BITS'(1)) begin
      sym_byte = 8'h27;
    end else if (s == SYM_BITS'(2)) begin
      sym_byte = 8'h2C;
    end else if (s <= SYM_LAST) begin
      sym_byte = 8'(s) + 8'h5E;
    end else begin
      sym_byte = 8'h00;
    end
  endfunction

  // reported counts clamp to the output width
  function automatic logic [OCNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
    logic [63:0] e;
    e = 64'(c);
    sat_count = (e > 64'hFFFF) ? {OCNT_BITS{1'b1}} : e[OCNT_BITS-1:0];
  endfunction

  function automatic logic [OTOT_BITS-1:0] sat_total(input logic [TOTAL_BITS-1:0] t);
    logic [63:0] e;
    e = 64'(t);
    sat_total = (e > 64'h1F_FFFF) ? {OTOT_BITS{1'b1}} : e[OTOT_BITS-1:0];
  endfunction

endpackage

FILE: src/ctc3_if.sv
// valid/ready channels for input and result beats
interface ctc3_in_if;
  import ctc3_pkg::*;
  logic     valid;
  logic     ready;
  ctc3_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ctc3_out_if;
  import ctc3_pkg::*;
  logic      valid;
  logic      ready;
  ctc3_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/ctc3_ram.sv
// generic single-port ram with registered read
module ctc3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: src/char_trigram_counter_top3_core.sv
// trigram counter: feed bytes into a counter table, query the top three followers of a pair
// feed beat: no table access when the byte is dropped or fewer than two symbols precede it,
//   else a ram read, then a saturating write back
// query beat: one table read per follower (29), none when a pair byte has no symbol code
// reset: history cleared at once, then a pass zeroes all 32768 table entries, one entry
//   per cycle, during which no beat is accepted
module char_trigram_counter_top3_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  ctc3_in_if.sink      in_if,
  ctc3_out_if.source   out_if
);
  import ctc3_pkg::*;

  ctc3_state_e state_q, state_d;

  logic [ADDR_BITS-1:0]  clr_addr_q;
  logic [SYM_BITS-1:0]   recent_q [2];
  logic [1:0]            seen_q;
  logic [ADDR_BITS-1:0]  upd_addr_q;
  logic [SYM_BITS-1:0]   qa_q, qb_q;
  logic [SYM_BITS-1:0]   k_q, cmp_k_q;
  logic [COUNT_BITS-1:0] cnt_q [3];
  logic [COUNT_BITS-1:0] cnt_d [3];
  logic [SYM_BITS-1:0]   chr_q [3];
  logic [SYM_BITS-1:0]   chr_d [3];
  logic [TOTAL_BITS-1:0] total_q;
  logic                  out_valid_q;
  ctc3_out_t             out_data_q;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_addr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic                  in_ready, in_fire, load_out;
  logic [SYM_BITS-1:0]   feed_sym, qa_sym, qb_sym;
  logic                  feed_kept, feed_count, query_ok;

  // counter table
  ctc3_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_if.ready  = in_ready;
  assign in_fire      = in_if.valid && in_ready;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  // symbol decode of the incoming beat
  assign feed_sym   = sym_of(in_if.data.char_in, 1'b1);
  assign qa_sym     = sym_of(in_if.data.first_letter, 1'b0);
  assign qb_sym     = sym_of(in_if.data.second_letter, 1'b0);
  assign feed_kept  = (feed_sym != SYM_NONE);
  assign feed_count = feed_kept && (seen_q == 2'd2);
  assign query_ok   = (qa_sym != SYM_NONE) && (qb_sym != SYM_NONE);

  // next state and table access
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_addr  = clr_addr_q;
    ram_wdata = '0;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_q == ADDR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.data.mode == MODE_FEED) begin
          ram_addr = {recent_q[0], recent_q[1], feed_sym};
        end else begin
          ram_addr = {qa_sym, qb_sym, SYM_BITS'(0)};
        end
        if (in_if.valid) begin
          if (in_if.data.mode == MODE_FEED) begin
            if (feed_count) begin
              state_d = ST_FEED;
            end
          end else if (query_ok) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FEED: begin
        ram_we    = 1'b1;
        ram_addr  = upd_addr_q;
        ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
        state_d   = ST_IDLE;
      end
      ST_WALK: begin
        ram_addr = {qa_q, qb_q, k_q};
        if (cmp_k_q == SYM_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // top-three insertion of the follower count just read
  always_comb begin
    cnt_d = cnt_q;
    chr_d = chr_q;
    priority if (ram_rdata > cnt_q[0]) begin
      cnt_d[2] = cnt_q[1];  chr_d[2] = chr_q[1];
      cnt_d[1] = cnt_q[0];  chr_d[1] = chr_q[0];
      cnt_d[0] = ram_rdata; chr_d[0] = cmp_k_q;
    end else if (ram_rdata > cnt_q[1]) begin
      cnt_d[2] = cnt_q[1];  chr_d[2] = chr_q[1];
      cnt_d[1] = ram_rdata; chr_d[1] = cmp_k_q;
    end else if (ram_rdata > cnt_q[2]) begin
      cnt_d[2] = ram_rdata; chr_d[2] = cmp_k_q;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      recent_q[0] <= '0;
      recent_q[1] <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
      end
      // symbol history
      if (in_fire && in_if.data.mode == MODE_FEED && feed_kept) begin
        recent_q[0] <= recent_q[1];
        recent_q[1] <= feed_sym;
        if (seen_q != 2'd2) begin
          seen_q <= seen_q + 2'd1;
        end
      end
      // result beat handshake
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      upd_addr_q <= {recent_q[0], recent_q[1], feed_sym};
      qa_q       <= qa_sym;
      qb_q       <= qb_sym;
      k_q        <= SYM_BITS'(1);
      cmp_k_q    <= '0;
      total_q    <= '0;
      for (int i = 0; i < 3; i++) begin
        cnt_q[i] <= '0;
        chr_q[i] <= '0;
      end
    end else if (state_q == ST_WALK) begin
      k_q     <= k_q + SYM_BITS'(1);
      cmp_k_q <= k_q;
      total_q <= total_q + TOTAL_BITS'(ram_rdata);
      cnt_q   <= cnt_d;
      chr_q   <= chr_d;
    end
    if (load_out) begin
      out_data_q.best_char    <= (cnt_q[0] != '0) ? sym_byte(chr_q[0]) : 8'h00;
      out_data_q.best_count   <= sat_count(cnt_q[0]);
      out_data_q.second_char  <= (cnt_q[1] != '0) ? sym_byte(chr_q[1]) : 8'h00;
      out_data_q.second_count <= sat_count(cnt_q[1]);
      out_data_q.third_char   <= (cnt_q[2] != '0) ? sym_byte(chr_q[2]) : 8'h00;
      out_data_q.third_count  <= sat_count(cnt_q[2]);
      out_data_q.total_count  <= sat_total(total_q);
      out_data_q.no_data      <= (total_q == '0);
    end
  end

endmodule

FILE: tb/sv/char_trigram_counter_top3_core_test.sv
// self-checking testbench for the trigram counter with top-three follower queries
module char_trigram_counter_top3_core_test;
  import ctc3_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_BEATS = 1600;
  localparam int unsigned FILL_BEATS = 64;
  localparam int unsigned DRAIN_CYCLES = 64;

  // tracks the counter table and the queue of expected top-three answers
  class trigram_scoreboard;
    logic [COUNT_BITS-1:0] tally [DEPTH];
    logic [SYM_BITS-1:0]   two_back;
    logic [SYM_BITS-1:0]   one_back;
    int unsigned           kept_so_far;
    ctc3_out_t             pending_tops [$];
    int unsigned           mismatches;

    function new();
      foreach (tally[i]) tally[i] = '0;
      two_back    = '0;
      one_back    = '0;
      kept_so_far = 0;
      mismatches  = 0;
    endfunction

    // byte to 5-bit symbol, capitals folded only when asked
    static function logic [SYM_BITS-1:0] symbol_code(logic [7:0] b, bit fold);
      logic [7:0] c;
      c = b;
      if (fold && c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      if (c >= 8'h61 && c <= 8'h7A) return SYM_BITS'(c - 8'h61 + 8'd3);
      if (c == 8'h20) return SYM_BITS'(0);
      if (c == 8'h27) return SYM_BITS'(1);
      if (c == 8'h2C) return SYM_BITS'(2);
      return SYM_NONE;
    endfunction

    // lower-case byte of follower k in walk order
    static function logic [7:0] follower_byte(int unsigned k);
      if (k == 0) return 8'h20;
      if (k == 1) return 8'h27;
      if (k == 2) return 8'h2C;
      return 8'(8'h61 + k - 3);
    endfunction

    static function logic [OCNT_BITS-1:0] out_count(longint unsigned v);
      return (v > 64'hFFFF) ? {OCNT_BITS{1'b1}} : OCNT_BITS'(v);
    endfunction

    // walk the 29 followers of a pair and keep the three largest
    function ctc3_out_t rank_followers(logic [7:0] fb, logic [7:0] sb);
      ctc3_out_t             r;
      logic [SYM_BITS-1:0]   a;
      logic [SYM_BITS-1:0]   b;
      logic [COUNT_BITS-1:0] c;
      logic [COUNT_BITS-1:0] cnt [3];
      logic [7:0]            chr [3];
      longint unsigned       sum;
      a = symbol_code(fb, 1'b0);
      b = symbol_code(sb, 1'b0);
      foreach (cnt[i]) begin
        cnt[i] = '0;
        chr[i] = '0;
      end
      sum = 0;
      if (a != SYM_NONE && b != SYM_NONE) begin
        for (int k = 0; k < SYM_COUNT; k++) begin
          c = tally[{a, b, SYM_BITS'(k)}];
          sum += c;
          // strict compares so ties stay with the earlier follower
          if (c > cnt[0]) begin
            cnt[2] = cnt[1]; chr[2] = chr[1];
            cnt[1] = cnt[0]; chr[1] = chr[0];
            cnt[0] = c;      chr[0] = follower_byte(k);
          end else if (c > cnt[1]) begin
            cnt[2] = cnt[1]; chr[2] = chr[1];
            cnt[1] = c;      chr[1] = follower_byte(k);
          end else if (c > cnt[2]) begin
            cnt[2] = c;      chr[2] = follower_byte(k);
          end
        end
      end
      r.best_char    = chr[0];
      r.best_count   = out_count(cnt[0]);
      r.second_char  = chr[1];
      r.second_count = out_count(cnt[1]);
      r.third_char   = chr[2];
      r.third_count  = out_count(cnt[2]);
      r.total_count  = (sum > 64'h1F_FFFF) ? {OTOT_BITS{1'b1}} : OTOT_BITS'(sum);
      r.no_data      = (sum == 0);
      return r;
    endfunction

    // accepted input beat: count a trigram or queue a query answer
    function void note_beat(ctc3_in_t b);
      logic [SYM_BITS-1:0]  s;
      logic [ADDR_BITS-1:0] idx;
      if (b.mode == MODE_QUERY) begin
        pending_tops.push_back(rank_followers(b.first_letter, b.second_letter));
        return;
      end
      s = symbol_code(b.char_in, 1'b1);
      if (s == SYM_NONE) return;
      if (kept_so_far >= 2) begin
        idx = {two_back, one_back, s};
        if (tally[idx] != COUNT_MAX) tally[idx] = tally[idx] + 1'b1;
      end else begin
        kept_so_far++;
      end
      two_back = one_back;
      one_back = s;
    endfunction

    task report_mismatch(string msg);
      // keep the log bounded when the block is badly off
      if (mismatches < 100) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // accepted result beat against the oldest expectation
    task check_result(ctc3_out_t got);
      ctc3_out_t want;
      if (pending_tops.size() == 0) begin
        report_mismatch("result beat with no query outstanding");
        return;
      end
      want = pending_tops.pop_front();
      compare_field("best_char", got.best_char, want.best_char);
      compare_field("best_count", got.best_count, want.best_count);
      compare_field("second_char", got.second_char, want.second_char);
      compare_field("second_count", got.second_count, want.second_count);
      compare_field("third_char", got.third_char, want.third_char);
      compare_field("third_count", got.third_count, want.third_count);
      compare_field("total_count", got.total_count, want.total_count);
      compare_field("no_data", got.no_data, want.no_data);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ctc3_in_if  in_ch ();
  ctc3_out_if out_ch ();

  char_trigram_counter_top3_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  trigram_scoreboard tops_sb = new();

  int unsigned in_gap_pct = 29;
  int unsigned out_gap_pct = 29;
  int unsigned hold_asks = 0;
  int unsigned cycle_count = 0;

  // small alphabet so trigrams repeat and ties show up
  logic [7:0] common_set [6] = '{8'h20, 8'h27, 8'h2C, 8'h61, 8'h65, 8'h7A};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("char_trigram_counter_top3_core_test NOT OK");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) tops_sb.check_result(out_ch.data);
  end

  // result receiver with random stalls and one long hold on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_gap_pct);
      end
    end
  end

  function automatic ctc3_in_t feed_beat(logic [7:0] c);
    ctc3_in_t b;
    b.mode          = MODE_FEED;
    b.char_in       = c;
    b.first_letter  = 8'($urandom);
    b.second_letter = 8'($urandom);
    return b;
  endfunction

  function automatic ctc3_in_t query_beat(logic [7:0] fb, logic [7:0] sb);
    ctc3_in_t b;
    b.mode          = MODE_QUERY;
    b.char_in       = 8'($urandom);
    b.first_letter  = fb;
    b.second_letter = sb;
    return b;
  endfunction

  // text byte: mostly the small alphabet, some capitals, some dropped bytes
  function automatic logic [7:0] random_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return common_set[$urandom_range(5)];
    if (r < 72) return common_set[$urandom_range(5, 3)] - 8'h20;
    if (r < 78) return 8'(8'h41 + $urandom_range(25));
    if (r < 88) return trigram_scoreboard::follower_byte($urandom_range(28));
    return 8'($urandom);
  endfunction

  // query byte: mostly the small alphabet, the rest never matches or is rare
  function automatic logic [7:0] random_pair_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return common_set[$urandom_range(5)];
    if (r < 80) return trigram_scoreboard::follower_byte($urandom_range(28));
    if (r < 90) return 8'(8'h41 + $urandom_range(25));
    return 8'($urandom);
  endfunction

  // one input beat, with optional idle cycles ahead of it
  task automatic send_beat(input ctc3_in_t b);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tops_sb.note_beat(b);
    @(negedge clk_i);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(feed_beat(s[i]));
  endtask

  // stimulus
  initial begin
    int unsigned forced_queries;
    forced_queries = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty table, dropped bytes, folding, tie between the second and third ranks
    send_beat(query_beat(8'h61, 8'h62));
    send_beat(feed_beat(8'h00));
    send_beat(feed_beat(8'hFF));
    feed_text("abcAbd@abcab'");
    send_beat(query_beat(8'h61, 8'h62));
    // capital in a query is not folded
    send_beat(query_beat(8'h41, 8'h62));
    send_beat(query_beat(8'hFF, 8'h00));
    send_beat(query_beat(8'h20, 8'h7A));
    send_beat(query_beat(8'h2C, 8'h27));
    feed_text("z ,");
    send_beat(query_beat(8'h7A, 8'h20));

    // random mix of feeds and queries
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // stretch with no idling on either side
      if (n == 600) begin
        in_gap_pct  = 0;
        out_gap_pct = 0;
      end
      if (n == 900) begin
        in_gap_pct  = 29;
        out_gap_pct = 29;
      end
      // long receiver hold while queries keep coming
      if (n == 1200) begin
        hold_asks++;
        forced_queries = 20;
      end
      if (forced_queries != 0) begin
        forced_queries--;
        send_beat(query_beat(random_pair_byte(), random_pair_byte()));
      end else if ($urandom_range(99) < 20) begin
        send_beat(query_beat(random_pair_byte(), random_pair_byte()));
      end else begin
        send_beat(feed_beat(random_text_byte()));
      end
    end

    // pile counts onto one trigram back to back, dropped bytes in between
    in_gap_pct = 0;
    for (int n = 0; n < FILL_BEATS; n++) begin
      case ($urandom_range(9))
        0: send_beat(feed_beat(8'h41));
        1: send_beat(feed_beat(8'h2E));
        default: send_beat(feed_beat(8'h61));
      endcase
    end
    send_beat(query_beat(8'h61, 8'h61));
    feed_text("aAa");
    send_beat(query_beat(8'h61, 8'h61));
    in_ch.valid <= 1'b0;

    // drain outstanding answers, then let the block settle
    while (tops_sb.pending_tops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tops_sb.mismatches == 0) begin
      $display("char_trigram_counter_top3_core_test OK");
    end else begin
      $display("char_trigram_counter_top3_core_test NOT OK");
    end
    $finish;
  end

endmodule
